// ===== hw/rtl/three_nearest_height_estimate_unit_defines.svh =====
// Assertion macros for the three-nearest height estimate unit.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef THREE_NEAREST_HEIGHT_ESTIMATE_UNIT_DEFINES_SVH
`define THREE_NEAREST_HEIGHT_ESTIMATE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define TNHE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TNHE_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define TNHE_ASSERT(label, prop, msg)
`define TNHE_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tnhe_pkg.sv =====
// Types and constants of the three-nearest height estimate unit.
// No dependencies; used by every module of the block.
package tnhe_pkg;

	localparam int COORD_BITS = 24;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int SQ_BITS    = 2 * DIFF_BITS;
	localparam int DIST_BITS  = SQ_BITS + 1;
	localparam int CNT_BITS   = 2;
	localparam int CFG_INDEX_BITS = 1;

	// 0.0001 in unsigned Q27.24
	localparam logic [DIST_BITS-1:0] EXACT_THRESH = DIST_BITS'(1678);

	localparam logic [CFG_INDEX_BITS-1:0] CFG_QUERY_X = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_QUERY_Z = 1'b1;

	localparam logic [CNT_BITS-1:0] CNT_ONE  = 2'd1;
	localparam logic [CNT_BITS-1:0] CNT_TWO  = 2'd2;
	localparam logic [CNT_BITS-1:0] CNT_FULL = 2'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [DIST_BITS-1:0] dist_t;

	typedef struct packed {
		coord_t vert_x;
		coord_t vert_y;
		coord_t vert_z;
		logic   last_vertex;
	} in_t;

	typedef struct packed {
		coord_t height_out;
		logic   found;
		logic   exact_hit;
	} out_t;

	// one classified vertex on its way from front to back
	typedef struct packed {
		dist_t  dist_sq;
		coord_t height;
		logic   counted;
		logic   last;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== hw/rtl/tnhe_front.sv =====
// Front end: accepts vertices, marks counted positions and forms the squared
// horizontal distance over two stages. Depends on tnhe_pkg.
module tnhe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tnhe_pkg::in_t    in_item,
	input  tnhe_pkg::coord_t query_x,
	input  tnhe_pkg::coord_t query_z,
	input  logic             q_full,
	output logic             push,
	output tnhe_pkg::work_t  push_item
);

	logic parity_q;

	logic                                v_s1;
	logic [tnhe_pkg::DIFF_BITS-1:0]      ax_s1;
	logic [tnhe_pkg::DIFF_BITS-1:0]      az_s1;
	tnhe_pkg::coord_t                    h_s1;
	logic                                cnt_s1;
	logic                                last_s1;

	logic                                v_s2;
	logic [tnhe_pkg::SQ_BITS-1:0]        sqx_s2;
	logic [tnhe_pkg::SQ_BITS-1:0]        sqz_s2;
	tnhe_pkg::coord_t                    h_s2;
	logic                                cnt_s2;
	logic                                last_s2;

	logic signed [tnhe_pkg::DIFF_BITS-1:0] dx;
	logic signed [tnhe_pkg::DIFF_BITS-1:0] dz;
	logic                                  rdy_s1;
	logic                                  rdy_s2;
	logic                                  acc;

	assign rdy_s2   = !v_s2 || !q_full;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign acc      = in_valid && rdy_s1;
	assign push     = v_s2 && !q_full;

	assign dx = tnhe_pkg::DIFF_BITS'(in_item.vert_x) - tnhe_pkg::DIFF_BITS'(query_x);
	assign dz = tnhe_pkg::DIFF_BITS'(in_item.vert_z) - tnhe_pkg::DIFF_BITS'(query_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (acc) begin
				parity_q <= in_item.last_vertex ? 1'b0 : ~parity_q;
			end
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ax_s1   <= dx[tnhe_pkg::DIFF_BITS-1] ? tnhe_pkg::DIFF_BITS'(-dx)
			                                     : tnhe_pkg::DIFF_BITS'(dx);
			az_s1   <= dz[tnhe_pkg::DIFF_BITS-1] ? tnhe_pkg::DIFF_BITS'(-dz)
			                                     : tnhe_pkg::DIFF_BITS'(dz);
			h_s1    <= in_item.vert_y;
			cnt_s1  <= !parity_q;
			last_s1 <= in_item.last_vertex;
		end
		if (rdy_s2 && v_s1) begin
			sqx_s2  <= tnhe_pkg::SQ_BITS'(ax_s1) * tnhe_pkg::SQ_BITS'(ax_s1);
			sqz_s2  <= tnhe_pkg::SQ_BITS'(az_s1) * tnhe_pkg::SQ_BITS'(az_s1);
			h_s2    <= h_s1;
			cnt_s2  <= cnt_s1;
			last_s2 <= last_s1;
		end
	end

	// sum cannot overflow: each square is below 2^49
	assign push_item.dist_sq = tnhe_pkg::DIST_BITS'(sqx_s2) + tnhe_pkg::DIST_BITS'(sqz_s2);
	assign push_item.height  = h_s2;
	assign push_item.counted = cnt_s2;
	assign push_item.last    = last_s2;

endmodule

// ===== hw/rtl/tnhe_queue.sv =====
// Short FIFO of classified vertices between front and back.
// Flip-flop storage, head read directly. Depends on tnhe_pkg.
module tnhe_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tnhe_pkg::work_t   push_item,
	input  logic              pop,
	output tnhe_pkg::work_t   head_item,
	output tnhe_pkg::q_stat_t stat
);

	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int LVL_BITS = $clog2(DEPTH + 1);

	tnhe_pkg::work_t     mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [LVL_BITS-1:0] level_q;

	assign stat.full  = (level_q == LVL_BITS'(DEPTH));
	assign stat.empty = (level_q == '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hw/rtl/tnhe_back.sv =====
// Back end: three-slot nearest insertion, end-of-run finish stage and the
// result register. Depends on tnhe_pkg.
module tnhe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  tnhe_pkg::work_t head_item,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output tnhe_pkg::out_t  out_item
);

	tnhe_pkg::dist_t               dist_q [3];
	tnhe_pkg::coord_t              hgt_q  [3];
	logic [tnhe_pkg::CNT_BITS-1:0] cnt_q;

	logic                          fin_v_s1;
	tnhe_pkg::dist_t               fin_d0_s1;
	tnhe_pkg::coord_t              fin_h_s1 [3];
	logic [tnhe_pkg::CNT_BITS-1:0] fin_cnt_s1;

	logic            out_valid_q;
	tnhe_pkg::out_t  out_item_q;

	tnhe_pkg::dist_t               nd [3];
	tnhe_pkg::coord_t              nh [3];
	logic [tnhe_pkg::CNT_BITS-1:0] ncnt;
	logic [2:0]                    take;
	logic                          p0, p1, p2;
	logic                          out_free;
	logic                          fin_ready;

	tnhe_pkg::coord_t                mn, mx;
	logic signed [tnhe_pkg::COORD_BITS:0] sum;
	tnhe_pkg::out_t                  res;

	assign out_free  = !out_valid_q || out_ready;
	assign fin_ready = !fin_v_s1 || out_free;
	assign pop       = head_valid && (!head_item.last || fin_ready);

	// a slot takes the vertex if unfilled or strictly farther; ties keep the older one
	assign take[0] = (cnt_q == '0) || (dist_q[0] > head_item.dist_sq);
	assign take[1] = (cnt_q <= tnhe_pkg::CNT_ONE) || (dist_q[1] > head_item.dist_sq);
	assign take[2] = (cnt_q <= tnhe_pkg::CNT_TWO) || (dist_q[2] > head_item.dist_sq);
	assign p0 = head_item.counted && take[0];
	assign p1 = head_item.counted && !take[0] && take[1];
	assign p2 = head_item.counted && !take[0] && !take[1] && take[2];

	always_comb begin
		nd[0] = p0 ? head_item.dist_sq : dist_q[0];
		nh[0] = p0 ? head_item.height  : hgt_q[0];
		nd[1] = p0 ? dist_q[0] : (p1 ? head_item.dist_sq : dist_q[1]);
		nh[1] = p0 ? hgt_q[0]  : (p1 ? head_item.height  : hgt_q[1]);
		nd[2] = (p0 || p1) ? dist_q[1] : (p2 ? head_item.dist_sq : dist_q[2]);
		nh[2] = (p0 || p1) ? hgt_q[1]  : (p2 ? head_item.height  : hgt_q[2]);
		ncnt  = ((p0 || p1 || p2) && (cnt_q != tnhe_pkg::CNT_FULL)) ? cnt_q + 1'b1 : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			fin_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cnt_q <= head_item.last ? '0 : ncnt;
			end
			if (pop && head_item.last) begin
				fin_v_s1 <= 1'b1;
			end else if (out_free) begin
				fin_v_s1 <= 1'b0;
			end
			if (fin_v_s1 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !head_item.last) begin
			dist_q <= nd;
			hgt_q  <= nh;
		end
		if (pop && head_item.last) begin
			fin_d0_s1  <= nd[0];
			fin_h_s1   <= nh;
			fin_cnt_s1 <= ncnt;
		end
		if (fin_v_s1 && out_free) begin
			out_item_q <= res;
		end
	end

	// finish: min and max over the filled slots only
	always_comb begin
		mn = fin_h_s1[0];
		mx = fin_h_s1[0];
		if (fin_cnt_s1 >= tnhe_pkg::CNT_TWO) begin
			if (fin_h_s1[1] < mn) mn = fin_h_s1[1];
			if (fin_h_s1[1] > mx) mx = fin_h_s1[1];
		end
		if (fin_cnt_s1 == tnhe_pkg::CNT_FULL) begin
			if (fin_h_s1[2] < mn) mn = fin_h_s1[2];
			if (fin_h_s1[2] > mx) mx = fin_h_s1[2];
		end
		sum = (tnhe_pkg::COORD_BITS + 1)'(mn) + (tnhe_pkg::COORD_BITS + 1)'(mx);
		res.found     = (fin_cnt_s1 != '0);
		res.exact_hit = res.found && (fin_d0_s1 < tnhe_pkg::EXACT_THRESH);
		if (!res.found) begin
			res.height_out = '0;
		end else if (res.exact_hit) begin
			res.height_out = fin_h_s1[0];
		end else begin
			res.height_out = sum[tnhe_pkg::COORD_BITS:1];
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== hw/rtl/three_nearest_height_estimate_unit.sv =====
// Top level of the three-nearest height estimate unit: query registers,
// front, queue and back. Depends on tnhe_pkg, tnhe_front, tnhe_queue, tnhe_back.
//
// channel   direction  handshake            payload
// in        input      in_valid / in_ready  in_item   (tnhe_pkg::in_t)
// out       output     out_valid/out_ready  out_item  (tnhe_pkg::out_t)
// cfg       input      cfg_we               cfg_index, cfg_data
//
// One vertex per cycle sustained unless the output stalls; the back's slot update is a
// feedback loop on the slot registers. out_valid follows an accepted last vertex via
// second distance stage, queue write, finish-register slot insertion, result register.
// Reset clears all control state; query registers reset to zero; no clearing pass.
// A stalled output fills the result register, finish stage, queue and front stages
// before in_ready drops; the queue holds QUEUE_DEPTH transactions.
`include "three_nearest_height_estimate_unit_defines.svh"

module three_nearest_height_estimate_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  tnhe_pkg::in_t                           in_item,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output tnhe_pkg::out_t                          out_item,
	input  logic                                    cfg_we,
	input  logic [tnhe_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [tnhe_pkg::COORD_BITS-1:0]         cfg_data
);

	tnhe_pkg::coord_t  query_x_q;
	tnhe_pkg::coord_t  query_z_q;
	logic              q_push;
	logic              q_pop;
	tnhe_pkg::work_t   push_item;
	tnhe_pkg::work_t   head_item;
	tnhe_pkg::q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tnhe_pkg::CFG_QUERY_X: query_x_q <= cfg_data;
				tnhe_pkg::CFG_QUERY_Z: query_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tnhe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.query_x   (query_x_q),
		.query_z   (query_z_q),
		.q_full    (q_stat.full),
		.push      (q_push),
		.push_item (push_item)
	);

	tnhe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head_item (head_item),
		.stat      (q_stat)
	);

	tnhe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_stat.empty),
		.head_item  (head_item),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

	`TNHE_ASSERT(a_q_stat_sane, !(q_stat.full && q_stat.empty), "queue both full and empty")
	`TNHE_ASSERT_IMPLY(a_no_push_full, q_push, !q_stat.full, "push into full queue")
	`TNHE_ASSERT_IMPLY(a_hit_found, out_valid && out_item.exact_hit, out_item.found, "hit without vertex")
	`TNHE_ASSERT_IMPLY(a_empty_run, out_valid && !out_item.found, (out_item.height_out == '0) && !out_item.exact_hit, "empty run result not cleared")

endmodule
